// ----- hdl/ols_pkg.sv -----
// Shared types and constants for the ordered list store.
// Holds the request/response payload structs, command and status codes,
// and the control struct broadcast to every cell. No dependencies.
`default_nettype none

package ols_pkg;

   localparam int WORD_W  = 32;
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 8;
   localparam int STAT_W  = 3;
   localparam int LEN_W   = 5;
   // Widest cell position needed over the whole supported capacity range.
   localparam int POS_W   = 8;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam cmd_type CMD_ADD_HEAD  = 3'd0;
   localparam cmd_type CMD_ADD_TAIL  = 3'd1;
   localparam cmd_type CMD_INSERT_AT = 3'd2;
   localparam cmd_type CMD_READ_AT   = 3'd3;
   localparam cmd_type CMD_DEL_HEAD  = 3'd4;
   localparam cmd_type CMD_DEL_TAIL  = 3'd5;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_READ_OOR = 3'd1;
   localparam status_type ST_EMPTY    = 3'd2;
   localparam status_type ST_APPENDED = 3'd3;
   localparam status_type ST_FULL     = 3'd4;

   localparam logic signed [WORD_W-1:0] MISS_WORD = -32'sd999;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [WORD_W-1:0]   data;
      logic [INDEX_W-1:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]   read_data;
      status_type                 status;
      logic [LEN_W-1:0]           length;
      logic                       is_empty;
   } rsp_type;

   // Broadcast to the cell row once per transfer.
   typedef struct packed {
      logic                       insert_en;
      logic                       delete_en;
      logic [POS_W-1:0]           pos;
      logic signed [WORD_W-1:0]   data;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/ols_cell.sv -----
// One storage cell of the ordered list row.
// Depends on ols_pkg for the broadcast control struct.
`default_nettype none

module ols_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                                 clock,
   input  wire ols_pkg::cell_ctl_type                ctl,
   input  wire logic signed [ols_pkg::WORD_W-1:0]    left_word,
   input  wire logic signed [ols_pkg::WORD_W-1:0]    right_word,
   output logic signed [ols_pkg::WORD_W-1:0]         word
);

   localparam logic [ols_pkg::POS_W-1:0] MyPos = ols_pkg::POS_W'(INDEX);

   logic signed [ols_pkg::WORD_W-1:0] word_ff;
   logic signed [ols_pkg::WORD_W-1:0] word_in;

   // An insert opens a gap at pos by moving every later cell up one place;
   // a delete closes the gap at pos by pulling every later cell down.
   always_comb begin
      word_in = word_ff;
      if (ctl.insert_en) begin
         if (MyPos > ctl.pos) begin
            word_in = left_word;
         end else if (MyPos == ctl.pos) begin
            word_in = ctl.data;
         end
      end else if (ctl.delete_en) begin
         if (MyPos >= ctl.pos) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

// ----- hdl/ordered_list_store_top.sv -----
// Top level of the ordered list store: command decode, fill count,
// the row of ols_cell instances and the response register. Uses ols_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | ols_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_ready  | ols_pkg::rsp_type
//
// Inserts and head deletes shift the cell row on the edge of the
// transfer, and every result appears in the response register
// on the following cycle. A new command is taken every cycle while the
// response side keeps up; the response register is the only stall point.
// Reset empties the list at once; cell contents are not cleared.
`default_nettype none

module ordered_list_store_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ols_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ols_pkg::rsp_type       rsp_payload
);

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CmpW = ((CntW > ols_pkg::INDEX_W) ? CntW : ols_pkg::INDEX_W) + 1;
   localparam int PosW = ols_pkg::POS_W;
   localparam int LenW = ols_pkg::LEN_W;

   logic [CntW-1:0]  count_ff;
   logic [CntW-1:0]  count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ols_pkg::rsp_type rsp_ff;
   ols_pkg::rsp_type rsp_in;

   ols_pkg::cell_ctl_type ctl;
   logic signed [ols_pkg::WORD_W-1:0] words [CAPACITY];

   logic                  req_fire;
   logic [ols_pkg::INDEX_W-1:0] k;
   logic [CmpW-1:0]       k_x;
   logic [CmpW-1:0]       cnt_x;
   logic                  full;
   logic                  empty;
   logic [AddrW-1:0]      rd_addr;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign k     = (req_payload.index == '0) ? ols_pkg::INDEX_W'(1) : req_payload.index;
   assign k_x   = CmpW'(k);
   assign cnt_x = CmpW'(count_ff);
   assign full  = (count_ff == CntW'(CAPACITY));
   assign empty = (count_ff == '0);
   // Only used when k is within the list, so k-1 is below CAPACITY.
   assign rd_addr = AddrW'(k - ols_pkg::INDEX_W'(1));

   always_comb begin
      ctl           = '0;
      ctl.data      = req_payload.data;
      count_in      = count_ff;
      rsp_in        = '0;
      if (req_fire) begin
         unique case (req_payload.cmd) inside
            ols_pkg::CMD_ADD_HEAD, ols_pkg::CMD_ADD_TAIL, ols_pkg::CMD_INSERT_AT: begin
               if (full) begin
                  rsp_in.status = ols_pkg::ST_FULL;
               end else begin
                  ctl.insert_en = 1'b1;
                  count_in      = count_ff + CntW'(1);
                  if (req_payload.cmd == ols_pkg::CMD_ADD_HEAD) begin
                     ctl.pos = '0;
                  end else if (req_payload.cmd == ols_pkg::CMD_ADD_TAIL) begin
                     ctl.pos = PosW'(count_ff);
                  end else if (k_x <= cnt_x + CmpW'(1)) begin
                     ctl.pos = PosW'(k - ols_pkg::INDEX_W'(1));
                  end else begin
                     ctl.pos       = PosW'(count_ff);
                     rsp_in.status = ols_pkg::ST_APPENDED;
                  end
               end
            end
            ols_pkg::CMD_READ_AT: begin
               if (k_x > cnt_x) begin
                  rsp_in.read_data = ols_pkg::MISS_WORD;
                  rsp_in.status    = ols_pkg::ST_READ_OOR;
               end else begin
                  rsp_in.read_data = words[rd_addr];
               end
            end
            ols_pkg::CMD_DEL_HEAD, ols_pkg::CMD_DEL_TAIL: begin
               if (empty) begin
                  rsp_in.status = ols_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - CntW'(1);
                  // Removing the tail needs no movement; the count drop hides it.
                  if (req_payload.cmd == ols_pkg::CMD_DEL_HEAD) begin
                     ctl.delete_en = 1'b1;
                     ctl.pos       = '0;
                  end
               end
            end
            default: begin
            end
         endcase
         rsp_in.length   = LenW'(count_in);
         rsp_in.is_empty = (count_in == '0);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ols_pkg::WORD_W-1:0] left_word;
      logic signed [ols_pkg::WORD_W-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_mid_l
         assign left_word = words[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = words[i];
      end else begin : g_mid_r
         assign right_word = words[i+1];
      end
      ols_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[i])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An insert into a full list must be dropped and reported.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && full && (req_payload.cmd == ols_pkg::CMD_ADD_HEAD ||
         req_payload.cmd == ols_pkg::CMD_ADD_TAIL ||
         req_payload.cmd == ols_pkg::CMD_INSERT_AT)
      |=> rsp_ff.status == ols_pkg::ST_FULL && $stable(count_ff))
      else $error("insert into full list was not dropped");

   // The fill count moves only on a transfer.
   assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("fill count changed without a transfer");

   // A read leaves the list length untouched.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.cmd == ols_pkg::CMD_READ_AT |=> $stable(count_ff))
      else $error("read changed the fill count");

   // The fill count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> count_ff <= CntW'(CAPACITY))
      else $error("fill count above capacity");

endmodule

`default_nettype wire
